>>> hw/rtl/dxd_pkg.sv
// Shared types and constants for the DoG extremum detector.
// No dependencies; every other RTL file imports this package.
package dxd_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = 12;
	localparam int HGT_W      = 13;
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = QPTR_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH        = 2'd0,
		REG_HEIGHT       = 2'd1,
		REG_BRIGHT_FLOOR = 2'd2,
		REG_CURV         = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_NONE     = 2'd0,
		CLS_KEYPOINT = 2'd1,
		CLS_DARK     = 2'd2,
		CLS_EDGE     = 2'd3
	} point_class_t;

	// [plane above/middle/below][row old..new][col old..new]
	typedef logic [2:0][2:0][2:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
		logic [7:0]       bright_floor;
		logic [7:0]       curv;
	} cfg_t;

	typedef struct packed {
		logic             eval;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		window_t          win;
	} job_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

>>> hw/rtl/dxd_front.sv
// Front end: raster counters, two-line store and 3x3x3 window.
// Depends on dxd_pkg; pushes one job per accepted beat into dxd_queue.
module dxd_front
	import dxd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3*PIX_W-1:0]   in_pix,
	input  qstat_t               qstat,
	output logic                 push,
	output job_t                 job
);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic               acc;

	logic               valid_s1;
	logic [3*PIX_W-1:0] pix_s1;
	logic [COL_W-1:0]   col_s1;
	logic               eval_s1;
	logic [COL_W-1:0]   x_s1;
	logic [ROW_W-1:0]   y_s1;
	logic [6*PIX_W-1:0] rd_s1;   // [47:24] row-2, [23:0] row-1

	logic [6*PIX_W-1:0] line_mem [MAX_WIDTH];

	window_t            win_q;
	window_t            win_nx;

	// Queue slots must cover what is queued plus the beat in flight.
	assign in_ready = ({1'b0, qstat.count} + {{QCNT_W{1'b0}}, valid_s1})
		< (QCNT_W+1)'(QDEPTH);
	assign acc      = in_valid && in_ready;
	assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc  = {1'b0, row_q} + (ROW_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				if (col_inc >= cfg.width) begin
					col_q <= '0;
					if (row_inc >= cfg.height) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[ROW_W-1:0];
					end
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= in_pix;
			col_s1  <= col_q;
			eval_s1 <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
			x_s1    <= col_q - COL_W'(1);
			y_s1    <= row_q - ROW_W'(1);
		end
	end

	// Line store: read on accept, write back the shifted pair in the cycle after.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= line_mem[col_q];
		end
		if (valid_s1) begin
			line_mem[col_s1] <= {rd_s1[3*PIX_W-1:0], pix_s1};
		end
	end

	always_comb begin
		win_nx = win_q;
		for (int p = 0; p < 3; p++) begin
			for (int r = 0; r < 3; r++) begin
				win_nx[p][r][0] = win_q[p][r][1];
				win_nx[p][r][1] = win_q[p][r][2];
			end
			win_nx[p][0][2] = rd_s1[3*PIX_W + PIX_W*p +: PIX_W];
			win_nx[p][1][2] = rd_s1[PIX_W*p +: PIX_W];
			win_nx[p][2][2] = pix_s1[PIX_W*p +: PIX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_nx;
		end
	end

	assign push     = valid_s1;
	assign job.eval = eval_s1;
	assign job.x    = eval_s1 ? x_s1 : '0;
	assign job.y    = eval_s1 ? y_s1 : '0;
	assign job.win  = win_nx;

endmodule

>>> hw/rtl/dxd_queue.sv
// Short job queue between front and back ends.
// Depends on dxd_pkg for job_t and queue depth.
module dxd_queue
	import dxd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   wr_job,
	input  logic   pop,
	output job_t   rd_job,
	output qstat_t qstat
);

	job_t              slot [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot[wr_ptr_q] <= wr_job;
		end
	end

	assign rd_job      = slot[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

endmodule

>>> hw/rtl/dxd_back.sv
// Back end: 26-neighbor extremum test, brightness check and Hessian edge test.
// Depends on dxd_pkg; pulls jobs from dxd_queue, drives the result register.
module dxd_back
	import dxd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  qstat_t           qstat,
	input  job_t             job,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output logic             res_center,
	output point_class_t     res_class,
	output logic [COL_W-1:0] res_x,
	output logic [ROW_W-1:0] res_y
);

	logic en;

	// stage 1: compares and Hessian terms
	logic               v_s1, ev_s1, ext_s1, dark_s1;
	logic [COL_W-1:0]   x_s1;
	logic [ROW_W-1:0]   y_s1;
	logic signed [9:0]  dxx_s1, dyy_s1, q_s1;
	logic signed [10:0] tr_s1;
	// stage 2: products
	logic               v_s2, ev_s2, ext_s2, dark_s2;
	logic [COL_W-1:0]   x_s2;
	logic [ROW_W-1:0]   y_s2;
	logic signed [19:0] pdd_s2, qq_s2;
	logic signed [21:0] tt_s2;
	// stage 3: determinant and left side
	logic               v_s3, ev_s3, ext_s3, dark_s3;
	logic [COL_W-1:0]   x_s3;
	logic [ROW_W-1:0]   y_s3;
	logic signed [24:0] det_s3;
	logic [32:0]        lhs_s3;
	// stage 4: right side
	logic               v_s4, ev_s4, ext_s4, dark_s4, neg_s4;
	logic [COL_W-1:0]   x_s4;
	logic [ROW_W-1:0]   y_s4;
	logic [32:0]        lhs_s4;
	logic signed [41:0] rhs_s4;

	logic [8:0]         rp1;
	logic [17:0]        rsq_full;
	logic [16:0]        rsq_q;

	logic [PIX_W-1:0]   c, n, s, w, e, nw, ne, sw, se;
	logic               all_gt, all_lt;
	logic signed [9:0]  dxx_c, dyy_c, q_c;
	logic               edge_c;
	point_class_t       cls_c;

	assign en  = !res_valid || res_ready;
	assign pop = en && !qstat.empty;

	assign c  = job.win[1][1][1];
	assign n  = job.win[1][0][1];
	assign s  = job.win[1][2][1];
	assign w  = job.win[1][1][0];
	assign e  = job.win[1][1][2];
	assign nw = job.win[1][0][0];
	assign ne = job.win[1][0][2];
	assign sw = job.win[1][2][0];
	assign se = job.win[1][2][2];

	always_comb begin
		all_gt = 1'b1;
		all_lt = 1'b1;
		for (int p = 0; p < 3; p++) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					if (!(p == 1 && r == 1 && k == 1)) begin
						if (!(job.win[p][r][k] > c)) all_gt = 1'b0;
						if (!(job.win[p][r][k] < c)) all_lt = 1'b0;
					end
				end
			end
		end
	end

	assign dxx_c = 10'(n) + 10'(s) - 10'({c, 1'b0});
	assign dyy_c = 10'(w) + 10'(e) - 10'({c, 1'b0});
	assign q_c   = 10'(nw) + 10'(se) - 10'(sw) - 10'(ne);

	assign rp1      = {1'b0, cfg.curv} + 9'd1;
	assign rsq_full = rp1 * rp1;

	always_ff @(posedge clk) begin
		rsq_q <= rsq_full[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= pop;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			res_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ev_s1   <= job.eval;
			x_s1    <= job.x;
			y_s1    <= job.y;
			ext_s1  <= all_gt || all_lt;
			dark_s1 <= c < cfg.bright_floor;
			dxx_s1  <= dxx_c;
			dyy_s1  <= dyy_c;
			q_s1    <= q_c;
			tr_s1   <= {dxx_c[9], dxx_c} + {dyy_c[9], dyy_c};

			ev_s2   <= ev_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			ext_s2  <= ext_s1;
			dark_s2 <= dark_s1;
			pdd_s2  <= dxx_s1 * dyy_s1;
			qq_s2   <= q_s1 * q_s1;
			tt_s2   <= tr_s1 * tr_s1;

			ev_s3   <= ev_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			ext_s3  <= ext_s2;
			dark_s3 <= dark_s2;
			det_s3  <= {pdd_s2[19], pdd_s2, 4'b0000} - {{5{qq_s2[19]}}, qq_s2};
			lhs_s3  <= {12'b0, tt_s2[20:0]} * {21'b0, cfg.curv, 4'b0000};

			ev_s4   <= ev_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			ext_s4  <= ext_s3;
			dark_s4 <= dark_s3;
			neg_s4  <= det_s3[24];
			lhs_s4  <= lhs_s3;
			rhs_s4  <= $signed({1'b0, rsq_q}) * det_s3;

			res_center <= ev_s4;
			res_class  <= cls_c;
			res_x      <= x_s4;
			res_y      <= y_s4;
		end
	end

	assign edge_c = neg_s4 || ($signed({9'b0, lhs_s4}) > rhs_s4);

	always_comb begin
		if (!ev_s4 || !ext_s4) begin
			cls_c = CLS_NONE;
		end else if (dark_s4) begin
			cls_c = CLS_DARK;
		end else if (edge_c) begin
			cls_c = CLS_EDGE;
		end else begin
			cls_c = CLS_KEYPOINT;
		end
	end

endmodule

>>> hw/rtl/dog_extremum_detector_unit.sv
// Top level of the DoG extremum detector: config registers, front, queue, back.
// Depends on dxd_pkg, dxd_front, dxd_queue and dxd_back.
//
// Takes three aligned 8-bit DoG planes (above, middle, below) as one pixel
// triple per beat in raster order and returns exactly one result beat per input
// beat. When the beat completes a 3x3x3 window around an interior middle pixel,
// center_valid is 1 and point_class tells whether that pixel is strictly above or
// below all 26 neighbors and, if so, whether it is dark (below the brightness
// floor), an edge (Hessian determinant negative or curvature ratio over
// (r+1)^2/r, done in exact integers) or a keypoint; center_x/center_y give its
// position. center_valid and point_class travel on tuser, the position on tdata.
// Other beats return all zeros. Throughput is one beat per clock while the
// result stream does not stall: the line store has one read and one write port
// and each beat uses each once. A 4-entry job queue sits between the window
// front end and the 5-stage classifier, so output back-pressure stalls only the
// classifier until the queue fills, after which s_axis_tready drops. The line
// store is not cleared at reset and needs no clearing pass: rows above the
// centre are written earlier in the frame unless the width is raised mid-frame.
// Width and height are clamped to [3, 2048] and [3, 4096]; write the
// configuration only while no beat is in flight.
module dog_extremum_detector_unit
	import dxd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // above_pixel, middle_pixel, below_pixel
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,  // center_x, center_y, zero pad
	output logic [2:0]           m_axis_tuser   // center_valid, point_class
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [7:0]       bright_floor_q;
	logic [7:0]       curv_q;
	cfg_t             cfg;

	qstat_t           qstat;
	logic             push;
	logic             pop;
	job_t             wr_job;
	job_t             rd_job;

	logic             res_center;
	point_class_t     res_class;
	logic [COL_W-1:0] res_x;
	logic [ROW_W-1:0] res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= WID_W'(640);
			height_q       <= HGT_W'(480);
			bright_floor_q <= 8'd6;
			curv_q         <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:        width_q        <= cfg_data[WID_W-1:0];
				REG_HEIGHT:       height_q       <= cfg_data[HGT_W-1:0];
				REG_BRIGHT_FLOOR: bright_floor_q <= cfg_data[7:0];
				REG_CURV:         curv_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// clamp frame size to what the counters and line store support
	always_comb begin
		if (width_q < WID_W'(3)) begin
			cfg.width = WID_W'(3);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			cfg.width = WID_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q < HGT_W'(3)) begin
			cfg.height = HGT_W'(3);
		end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
			cfg.height = HGT_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.bright_floor = bright_floor_q;
		cfg.curv         = curv_q;
	end

	dxd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_pix   (s_axis_tdata),
		.qstat    (qstat),
		.push     (push),
		.job      (wr_job)
	);

	dxd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.qstat  (qstat)
	);

	dxd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.qstat      (qstat),
		.job        (rd_job),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_center (res_center),
		.res_class  (res_class),
		.res_x      (res_x),
		.res_y      (res_y)
	);

	assign m_axis_tuser = {res_class, res_center};
	assign m_axis_tdata = {1'b0, res_y, res_x};

	// queue never overflows: front throttles on count plus in-flight beat
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (qstat.count != QCNT_W'(QDEPTH)) || pop)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job queue underflow");

	// beats without an evaluated centre carry all-zero fields
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0])
		|-> (m_axis_tuser[2:1] == '0 && m_axis_tdata == '0))
		else $error("non-centre result with nonzero fields");

endmodule

>>> tb/sv/tb_dog_extremum_detector_unit.sv
// Self-checking bench for dog_extremum_detector_unit: streams DoG pixel triples,
// predicts every result beat locally and compares it field by field.
// Depends on dxd_pkg and the detector RTL.
module tb_dog_extremum_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dxd_pkg::*;

	// one expected result beat, unpacked
	typedef struct {
		logic             valid;
		point_class_t     cls;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
	} center_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;   // above_pixel, middle_pixel, below_pixel
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;        // center_x, center_y, zero pad
	logic [2:0]           m_axis_tuser;        // center_valid, point_class

	// beats waiting for the driver, and result beats still owed by the DUT
	logic [23:0]    pixel_q[$];
	center_result_t center_q[$];
	center_result_t want;

	int unsigned src_idle = 32;    // percent of cycles the sender holds off
	int unsigned sink_idle = 87;   // percent of cycles the receiver stalls
	int unsigned mismatch_count = 0;
	int unsigned queued_beats = 0; // beats handed to the driver so far

	// local copy of the detector state
	logic [WID_W-1:0] width_reg;
	logic [HGT_W-1:0] height_reg;
	logic [7:0]       bright_reg;
	logic [7:0]       curv_reg;
	logic [23:0]      line_up1[MAX_WIDTH];   // triple one row above
	logic [23:0]      line_up2[MAX_WIDTH];   // triple two rows above
	int               win[3][3][3];          // [plane][row old..new][col old..new]
	int unsigned      col_cnt;
	int unsigned      row_cnt;

	always #5 clk = ~clk;

	dog_extremum_detector_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	// 26-neighbor extremum test, then dark / Hessian edge / keypoint
	function automatic point_class_t classify_center();
		int     c;
		bit     above_all;
		bit     below_all;
		longint dxx, dyy, q, tr, det16, rr;
		c = win[1][1][1];
		above_all = 1'b1;
		below_all = 1'b1;
		for (int p = 0; p < 3; p++)
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					if (!(p == 1 && r == 1 && k == 1)) begin
						if (win[p][r][k] <= c) above_all = 1'b0;
						if (win[p][r][k] >= c) below_all = 1'b0;
					end
		if (!above_all && !below_all) return CLS_NONE;
		if (c < int'(bright_reg)) return CLS_DARK;
		dxx = win[1][0][1] + win[1][2][1] - 2 * c;
		dyy = win[1][1][0] + win[1][1][2] - 2 * c;
		q = win[1][0][0] + win[1][2][2] - win[1][2][0] - win[1][0][2];
		tr = dxx + dyy;
		det16 = 16 * dxx * dyy - q * q;
		rr = curv_reg;
		if (det16 < 0) return CLS_EDGE;
		// det16 == 0 with a nonzero trace lands here as an edge unless r is zero
		if (16 * rr * tr * tr > (rr + 1) * (rr + 1) * det16) return CLS_EDGE;
		return CLS_KEYPOINT;
	endfunction

	task automatic reset_model();
		width_reg = 640;
		height_reg = 480;
		bright_reg = 6;
		curv_reg = 10;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_up1[i] = '0;
			line_up2[i] = '0;
		end
		for (int p = 0; p < 3; p++)
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					win[p][r][k] = 0;
		col_cnt = 0;
		row_cnt = 0;
	endtask

	// advance the local state by one accepted beat and queue its result
	task automatic predict_beat(input logic [23:0] beat);
		int unsigned    col;
		logic [23:0]    up1;
		logic [23:0]    up2;
		center_result_t res;
		col = col_cnt & (MAX_WIDTH - 1);
		up1 = line_up1[col];
		up2 = line_up2[col];
		line_up2[col] = up1;
		line_up1[col] = beat;
		for (int p = 0; p < 3; p++) begin
			for (int r = 0; r < 3; r++) begin
				win[p][r][0] = win[p][r][1];
				win[p][r][1] = win[p][r][2];
			end
			win[p][0][2] = up2[8*p +: 8];
			win[p][1][2] = up1[8*p +: 8];
			win[p][2][2] = beat[8*p +: 8];
		end
		res.valid = 1'b0;
		res.cls = CLS_NONE;
		res.x = '0;
		res.y = '0;
		if (col_cnt >= 2 && row_cnt >= 2) begin
			res.valid = 1'b1;
			res.cls = classify_center();
			res.x = COL_W'(col_cnt - 1);
			res.y = ROW_W'(row_cnt - 1);
		end
		center_q.insert(center_q.size(), res);
		// bounds take effect at once; a counter past a shrunk bound wraps next step
		col_cnt++;
		if (col_cnt >= clamp_size(width_reg, MAX_WIDTH)) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= clamp_size(height_reg, MAX_HEIGHT)) row_cnt = 0;
		end
	endtask

	// driver: one beat per handshake, random hold-off set by src_idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle) begin
					s_axis_tdata <= pixel_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (center_q.size() == 0) begin
					$error("result beat with nothing expected, tdata %h", m_axis_tdata);
					mismatch_count++;
				end else begin
					want = center_q.pop_front();
					if (m_axis_tuser[0] !== want.valid) begin
						$error("center_valid: expected %0d, got %0d", want.valid,
							m_axis_tuser[0]);
						mismatch_count++;
					end
					if (m_axis_tuser[2:1] !== want.cls) begin
						$error("point_class: expected %0d, got %0d", want.cls,
							m_axis_tuser[2:1]);
						mismatch_count++;
					end
					if (m_axis_tdata[10:0] !== want.x) begin
						$error("center_x: expected %0d, got %0d", want.x, m_axis_tdata[10:0]);
						mismatch_count++;
					end
					if (m_axis_tdata[22:11] !== want.y) begin
						$error("center_y: expected %0d, got %0d", want.y, m_axis_tdata[22:11]);
						mismatch_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// register writes only happen with the pipe empty
	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			REG_WIDTH:        width_reg = value[WID_W-1:0];
			REG_HEIGHT:       height_reg = value[HGT_W-1:0];
			REG_BRIGHT_FLOOR: bright_reg = value[7:0];
			REG_CURV:         curv_reg = value[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// sender pauses until every owed result is back, plus the pipe latency
	task automatic drain();
		while (pixel_q.size() != 0 || s_axis_tvalid || center_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// beats left until the counters are back at the top-left pixel
	function automatic int unsigned beats_to_frame_start();
		int unsigned c, r, n;
		c = col_cnt;
		r = row_cnt;
		n = 0;
		while (c != 0 || r != 0 || n == 0) begin
			if (c == 0 && r == 0) break;
			n++;
			c++;
			if (c >= clamp_size(width_reg, MAX_WIDTH)) begin
				c = 0;
				r++;
				if (r >= clamp_size(height_reg, MAX_HEIGHT)) r = 0;
			end
		end
		return n;
	endfunction

	task automatic push_noise(input int unsigned n);
		repeat (n) pixel_q.insert(pixel_q.size(), 24'($urandom));
		queued_beats += n;
	endtask

	// 3x3 frame, one window: above/below flat, middle plane shaped around c
	task automatic push_window_frame(input int ring, input int c, input int arm,
			input int diag_a, input int diag_b);
		int mid;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++) begin
				if (r == 1 && k == 1) mid = c;
				else if (r == 1 || k == 1) mid = arm;
				else if (r == k) mid = diag_a;      // NW and SE
				else mid = diag_b;                  // SW and NE
				pixel_q.insert(pixel_q.size(), {8'(ring), 8'(mid), 8'(ring)});
				queued_beats++;
			end
	endtask

	// noise frame with planted peaks and pits; first n beats in raster order
	task automatic push_planted(input int w, input int h, input int n);
		int img[3][16][16];
		int c, lim, sgn, a, b, d, cnt;
		for (int p = 0; p < 3; p++)
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					img[p][y][x] = $urandom_range(255);
		for (int y = 1; y < h - 1; y++)
			for (int x = 1; x < w - 1; x++)
				if ($urandom_range(4) == 0) begin
					sgn = $urandom_range(1) ? 1 : -1;
					c = ($urandom_range(3) == 0) ? $urandom_range(24) : $urandom_range(255);
					if (sgn > 0 && c == 0) c = 1;
					if (sgn < 0 && c == 255) c = 254;
					lim = (sgn > 0) ? c : 255 - c;
					if (lim > 60) lim = 60;
					// separate drops along rows and columns steer keypoint vs edge
					a = $urandom_range(lim, 1);
					b = $urandom_range(lim, 1);
					for (int p = 0; p < 3; p++)
						for (int dy = -1; dy <= 1; dy++)
							for (int dx = -1; dx <= 1; dx++) begin
								d = $urandom_range(lim, 1);
								if (p == 1 && dx == 0) d = a;
								else if (p == 1 && dy == 0) d = b;
								img[p][y+dy][x+dx] = c - sgn * d;
							end
					img[1][y][x] = c;
				end
		cnt = 0;
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				if (cnt < n) begin
					pixel_q.insert(pixel_q.size(),
						{8'(img[2][y][x]), 8'(img[1][y][x]), 8'(img[0][y][x])});
					cnt++;
				end
		queued_beats += cnt;
	endtask

	initial begin
		int unsigned nw, nh, v, n, ew, eh, phase;
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: smallest frame, sizes below range clamp up to 3x3
		write_reg(REG_WIDTH, 1);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_BRIGHT_FLOOR, 6);
		write_reg(REG_CURV, 10);
		// pit of 0 among 255s: dark minimum, both pixel extremes on the middle plane
		push_window_frame(255, 0, 255, 255, 255);
		// flat Hessian determinant with nonzero trace: edge
		push_window_frame(99, 100, 99, 99, 95);
		drain();
		// same window with ratio zero: edge test reduces to det16 < 0, so keypoint
		write_reg(REG_CURV, 0);
		push_window_frame(99, 100, 99, 99, 95);
		drain();

		phase = 0;
		while (queued_beats < 1000) begin
			drain();
			if (queued_beats < 350) begin
				src_idle = 32;
				sink_idle = 87;
			end else if (queued_beats < 700) begin
				src_idle = 87;
				sink_idle = 32;
			end else begin
				src_idle = 0;
				sink_idle = 0;
			end
			case (phase)
				2: begin
					// tall frame, then shrink the height below the current row
					write_reg(REG_WIDTH, 3);
					push_noise(beats_to_frame_start());
					drain();
					write_reg(REG_HEIGHT, MAX_HEIGHT);
					push_noise(3 * 40);
					drain();
					write_reg(REG_HEIGHT, 8191);
					push_noise(30);
					drain();
					write_reg(REG_HEIGHT, 5);
					push_noise(beats_to_frame_start());
				end
				5: begin
					// oversized width clamps to the widest line, then shrink mid-line
					push_noise(beats_to_frame_start());
					drain();
					write_reg(REG_WIDTH, 4095);
					write_reg(REG_HEIGHT, 3);
					push_noise(100);
					drain();
					write_reg(REG_WIDTH, MAX_WIDTH);
					push_noise(50);
					drain();
					write_reg(REG_WIDTH, 7);
					push_noise(beats_to_frame_start());
				end
				default: begin
					nw = $urandom_range(12);
					nh = $urandom_range(8);
					// widening mid-frame would read line-store columns never written
					if (clamp_size(nw, MAX_WIDTH) > clamp_size(width_reg, MAX_WIDTH)) begin
						push_noise(beats_to_frame_start());
						drain();
					end
					write_reg(REG_WIDTH, nw);
					write_reg(REG_HEIGHT, nh);
					case ($urandom_range(3))
						0:       v = 0;
						1:       v = 255;
						default: v = $urandom_range(30);
					endcase
					write_reg(REG_BRIGHT_FLOOR, v);
					case ($urandom_range(4))
						0:       v = 0;
						1:       v = 1;
						2:       v = 255;
						default: v = $urandom_range(20, 2);
					endcase
					write_reg(REG_CURV, v);
					// realign to the frame start so planted windows land in place
					n = beats_to_frame_start();
					push_noise(n);
					ew = clamp_size(width_reg, MAX_WIDTH);
					eh = clamp_size(height_reg, MAX_HEIGHT);
					repeat ($urandom_range(2, 1)) begin
						push_planted(ew, eh, ew * eh);
					end
					// sometimes stop mid-frame so the next settings land mid-frame
					if ($urandom_range(2) == 0) begin
						n = $urandom_range(ew * eh - 1, 1);
						push_planted(ew, eh, n);
					end
				end
			endcase
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && center_q.size() == 0) begin
			$display("[dog_extremum_detector_unit] OK");
		end else begin
			$display("[dog_extremum_detector_unit] ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(5_000_000);
		$display("[dog_extremum_detector_unit] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/dxd_pkg.sv
hw/rtl/dxd_front.sv
hw/rtl/dxd_queue.sv
hw/rtl/dxd_back.sv
hw/rtl/dog_extremum_detector_unit.sv
tb/sv/tb_dog_extremum_detector_unit.sv
